FILE: hw/rtl/ihex_pkg.sv
// Shared types and constants for the Intel HEX record parser.
`timescale 1ns / 1ps
`default_nettype none

package ihex_pkg;

    // Record parsing phases; unused codes of the 3-bit encoding behave as idle.
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_COUNT = 3'd1,
        PH_ADDR  = 3'd2,
        PH_TYPE  = 3'd3,
        PH_DATA  = 3'd4,
        PH_CHECK = 3'd5
    } phase_t;

    localparam logic [7:0] CHAR_COLON = 8'd58;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_UPA   = 8'd65;
    localparam logic [7:0] CHAR_UPF   = 8'd70;
    localparam logic [7:0] CHAR_ALPHA_OFS = 8'd55;

    // Number of address digits in a record.
    localparam logic [2:0] ADDR_DIGITS = 3'd4;

    localparam int TDATA_W = 80;

endpackage

`default_nettype wire

FILE: hw/rtl/intel_hex_record_parser.sv
// Top level of the Intel HEX record parser: character intake, parse state and result word.
`timescale 1ns / 1ps
`default_nettype none

// Intel HEX record parser. Each input word carries one ASCII character; the block
// waits for ':' and then reads the byte count, four address digits (most
// significant first), the record type, the data bytes and the checksum. Only the
// uppercase digits 0-9 and A-F are hex; any other character inside a record sets
// the bad-digit flag and contributes its low four bits. Characters between
// records, CR and LF included, are dropped. Every completed data byte produces
// one result word, and the checksum (reported as read, not verified) produces a
// summary word with the incremented record count. The block takes one character
// per clock cycle unless a full output register holds it back: a character is
// held in an input register, decoded by a single level of logic that updates the
// parse state, and any result lands in an output register. A completed result
// word is registered in the output register before it is presented on the master
// side, and a full output register only stalls intake while it is not being taken.
module intel_hex_record_parser
    import ihex_pkg::*;
(
    input  wire                 aclk,
    input  wire                 aresetn,

    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire  [7:0]          s_tdata,   // [7:0] char_in

    output logic                m_tvalid,
    input  wire                 m_tready,
    // [7:0] data_byte, [15:8] data_index, [23:16] record length, [39:24] load_address,
    // [47:40] record_type, [55:48] checksum_byte, [71:56] record_number,
    // [72] bad_digit, [79:73] zero
    output logic [TDATA_W-1:0]  m_tdata,
    output logic                m_tuser    // [0] is_summary
);

    // Input register.
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_char_reg;

    // Parse state.
    phase_t      phase_reg, phase_next;
    logic [2:0]  digit_cnt_reg, digit_cnt_next;
    logic [3:0]  high_nib_reg, high_nib_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  data_cnt_reg, data_cnt_next;
    logic [15:0] records_reg, records_next;
    logic        bad_reg, bad_next;

    // Output register.
    logic        out_valid_reg, out_valid_next;
    logic        out_summary_reg, out_summary_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic [7:0]  out_index_reg, out_index_next;
    logic [7:0]  out_count_reg, out_count_next;
    logic [15:0] out_addr_reg, out_addr_next;
    logic [7:0]  out_type_reg, out_type_next;
    logic [7:0]  out_chk_reg, out_chk_next;
    logic [15:0] out_recnum_reg, out_recnum_next;
    logic        out_bad_reg, out_bad_next;

    logic        advance;
    logic        emit;
    logic [3:0]  nib;
    logic        nib_bad;
    logic [7:0]  byte_val;
    logic [7:0]  data_cnt_inc;
    logic [2:0]  addr_cnt_inc;
    logic [7:0]  alpha_val;

    // The held character moves on whenever the output register has room for its result.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign alpha_val    = in_char_reg - CHAR_ALPHA_OFS;
    assign byte_val     = {high_nib_reg, nib};
    assign data_cnt_inc = data_cnt_reg + 8'd1;
    assign addr_cnt_inc = digit_cnt_reg + 3'd1;

    // Hex digit decode; a non-hex character keeps its low four bits and is flagged.
    always_comb begin
        if (in_char_reg >= CHAR_ZERO && in_char_reg <= CHAR_NINE) begin
            nib     = in_char_reg[3:0];
            nib_bad = 1'b0;
        end else if (in_char_reg >= CHAR_UPA && in_char_reg <= CHAR_UPF) begin
            nib     = alpha_val[3:0];
            nib_bad = 1'b0;
        end else begin
            nib     = in_char_reg[3:0];
            nib_bad = 1'b1;
        end
    end

    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;

    // Next parse state and result for the held character.
    always_comb begin
        phase_next       = phase_reg;
        digit_cnt_next   = digit_cnt_reg;
        high_nib_next    = high_nib_reg;
        count_next       = count_reg;
        addr_next        = addr_reg;
        type_next        = type_reg;
        data_cnt_next    = data_cnt_reg;
        records_next     = records_reg;
        bad_next         = bad_reg;
        emit             = 1'b0;
        out_summary_next = out_summary_reg;
        out_byte_next    = out_byte_reg;
        out_index_next   = out_index_reg;
        out_count_next   = out_count_reg;
        out_addr_next    = out_addr_reg;
        out_type_next    = out_type_reg;
        out_chk_next     = out_chk_reg;
        out_recnum_next  = out_recnum_reg;
        out_bad_next     = out_bad_reg;

        if (advance) begin
            case (phase_reg)
                PH_COUNT, PH_ADDR, PH_TYPE, PH_DATA, PH_CHECK: begin
                    if (nib_bad) begin
                        bad_next = 1'b1;
                    end
                    if (phase_reg == PH_ADDR) begin
                        addr_next = {addr_reg[11:0], nib};
                        if (addr_cnt_inc >= ADDR_DIGITS) begin
                            digit_cnt_next = 3'd0;
                            phase_next     = PH_TYPE;
                        end else begin
                            digit_cnt_next = addr_cnt_inc;
                        end
                    end else if (digit_cnt_reg == 3'd0) begin
                        high_nib_next  = nib;
                        digit_cnt_next = 3'd1;
                    end else begin
                        digit_cnt_next = 3'd0;
                        case (phase_reg)
                            PH_COUNT: begin
                                count_next = byte_val;
                                phase_next = PH_ADDR;
                            end
                            PH_TYPE: begin
                                type_next     = byte_val;
                                data_cnt_next = 8'd0;
                                phase_next    = (count_reg == 8'd0) ? PH_CHECK : PH_DATA;
                            end
                            PH_DATA: begin
                                emit             = 1'b1;
                                out_summary_next = 1'b0;
                                out_byte_next    = byte_val;
                                out_index_next   = data_cnt_reg;
                                out_chk_next     = 8'd0;
                                out_recnum_next  = records_reg;
                                data_cnt_next    = data_cnt_inc;
                                if (data_cnt_inc >= count_reg) begin
                                    phase_next = PH_CHECK;
                                end
                            end
                            default: begin
                                // Checksum complete: close the record.
                                emit             = 1'b1;
                                records_next     = records_reg + 16'd1;
                                out_summary_next = 1'b1;
                                out_byte_next    = 8'd0;
                                out_index_next   = 8'd0;
                                out_chk_next     = byte_val;
                                out_recnum_next  = records_reg + 16'd1;
                                phase_next       = PH_IDLE;
                            end
                        endcase
                        out_count_next = count_reg;
                        out_addr_next  = addr_reg;
                        out_type_next  = type_reg;
                        out_bad_next   = bad_reg | nib_bad;
                    end
                end
                default: begin
                    // Idle, or an unused code: wait for the start of a record.
                    phase_next = PH_IDLE;
                    if (in_char_reg == CHAR_COLON) begin
                        phase_next     = PH_COUNT;
                        digit_cnt_next = 3'd0;
                        high_nib_next  = 4'd0;
                        count_next     = 8'd0;
                        addr_next      = 16'd0;
                        type_next      = 8'd0;
                        data_cnt_next  = 8'd0;
                        bad_next       = 1'b0;
                    end
                end
            endcase
        end

        if (advance) begin
            out_valid_next = emit;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            digit_cnt_reg <= 3'd0;
            high_nib_reg  <= 4'd0;
            count_reg     <= 8'd0;
            addr_reg      <= 16'd0;
            type_reg      <= 8'd0;
            data_cnt_reg  <= 8'd0;
            records_reg   <= 16'd0;
            bad_reg       <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            digit_cnt_reg <= digit_cnt_next;
            high_nib_reg  <= high_nib_next;
            count_reg     <= count_next;
            addr_reg      <= addr_next;
            type_reg      <= type_next;
            data_cnt_reg  <= data_cnt_next;
            records_reg   <= records_next;
            bad_reg       <= bad_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_char_reg <= s_tdata;
        end
        out_summary_reg <= out_summary_next;
        out_byte_reg    <= out_byte_next;
        out_index_reg   <= out_index_next;
        out_count_reg   <= out_count_next;
        out_addr_reg    <= out_addr_next;
        out_type_reg    <= out_type_next;
        out_chk_reg     <= out_chk_next;
        out_recnum_reg  <= out_recnum_next;
        out_bad_reg     <= out_bad_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_summary_reg;
    assign m_tdata  = {7'd0, out_bad_reg, out_recnum_reg, out_chk_reg, out_type_reg,
                       out_addr_reg, out_count_reg, out_index_reg, out_byte_reg};

endmodule

`default_nettype wire
